@@ hdl/uet_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transceiver package
// Shared types, register indexes and reset values of the half-duplex UART.
// ----------------------------------------------------------------------------
package uet_pkg;

    localparam int DATA_WIDTH_DEF = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SAMPLE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ENABLE      = 2'd2;

    localparam logic [7:0] BIT_PERIOD_RST         = 8'd104;
    localparam logic [7:0] FIRST_SAMPLE_DELAY_RST = 8'd150;

    typedef enum logic [4:0] {
        TX_IDLE   = 5'b00001,
        TX_START  = 5'b00010,
        TX_DATA   = 5'b00100,
        TX_PARITY = 5'b01000,
        TX_STOP   = 5'b10000
    } tx_phase_t;

    typedef enum logic [3:0] {
        RX_IDLE   = 4'b0001,
        RX_DATA   = 4'b0010,
        RX_PARITY = 4'b0100,
        RX_STOP   = 4'b1000
    } rx_phase_t;

    typedef struct packed {
        logic [7:0] period;
        logic [7:0] first_delay;
        logic       parity_en;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic busy_next;
        logic line_next;
    } tx_status_t;

    typedef struct packed {
        logic       idle;
        logic       busy_next;
        logic       valid;
        logic [7:0] rx_data;
    } rx_status_t;

    // A timer load of zero behaves as one tick.
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

@@ hdl/uart_transceiver_even_parity_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Half-duplex UART transceiver, one tick per beat
// Input beats are clock ticks of the bit timers; each gives one result beat.
// ----------------------------------------------------------------------------
// Registers: an accepted input beat is held in the input register; then the
// state update, one pass of short logic, loads the result register.
// Throughput: one beat per cycle while the result side is not stalled.
// Reset: rst_n clears both sequencers to idle, counters and shift registers to
// zero, the registers to 104, 150 and 0, and empties both stages.
module uart_transceiver_even_parity_unit #(
    parameter int DATA_WIDTH = uet_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input: [0] rx_line, [1] tx_request, [9:2] tx_data, [15:10] zero
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [15:0]                    s_tdata,
    // Output: [0] tx_line, [1] tx_accepted, [2] link_busy, [3] rx_valid,
    // [11:4] rx_byte, [15:12] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,
    input  logic                           cfg_we,
    input  logic [uet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uet_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    uet_pkg::cfg_t       cfg_reg;
    uet_pkg::tx_status_t tx_status;
    uet_pkg::rx_status_t rx_status;

    logic                in_vld_reg;
    logic [15:0]         in_data_reg;
    logic                out_vld_reg;
    logic [15:0]         out_data_reg, out_data_next;
    logic                advance;
    logic                rx_in;
    logic                tx_req;
    logic                both_idle;
    logic                rx_start;
    logic                tx_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period      <= uet_pkg::BIT_PERIOD_RST;
            cfg_reg.first_delay <= uet_pkg::FIRST_SAMPLE_DELAY_RST;
            cfg_reg.parity_en   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                uet_pkg::CFG_BIT_PERIOD:         cfg_reg.period      <= cfg_wdata;
                uet_pkg::CFG_FIRST_SAMPLE_DELAY: cfg_reg.first_delay <= cfg_wdata;
                uet_pkg::CFG_PARITY_ENABLE:      cfg_reg.parity_en   <= cfg_wdata[0];
                default:                         ;
            endcase
        end
    end

    // A tick is applied when the result register is free or being emptied.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    assign rx_in     = in_data_reg[0];
    assign tx_req    = in_data_reg[1];
    assign both_idle = tx_status.idle && rx_status.idle;
    assign rx_start  = advance && both_idle && !rx_in;
    assign tx_start  = advance && both_idle && rx_in && tx_req;

    uet_tx #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_tx (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .start  (tx_start),
        .data   (in_data_reg[2 +: DATA_WIDTH]),
        .cfg    (cfg_reg),
        .status (tx_status)
    );

    uet_rx #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_rx (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .start  (rx_start),
        .rx_in  (rx_in),
        .cfg    (cfg_reg),
        .status (rx_status)
    );

    assign out_data_next = {4'd0,
                            rx_status.rx_data,
                            rx_status.valid,
                            tx_status.busy_next || rx_status.busy_next,
                            tx_start,
                            tx_status.line_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // Half duplex: the two sequencers are never active together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(!tx_status.idle && !rx_status.idle))
    else $error("transmitter and receiver active at once");

    // An accepted request always leaves the link busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[2])
    else $error("request taken without a busy link");

    // A received byte and an accepted request never share one beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[1] && m_tdata[3]))
    else $error("receive and transmit events on one beat");

    // Every applied tick leaves a result beat behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
    else $error("applied tick produced no result beat");

endmodule

@@ hdl/uet_tx.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmitter
// Frame sequencer for start, data, optional even parity and stop bits.
// ----------------------------------------------------------------------------
module uet_tx #(
    parameter int DATA_WIDTH = uet_pkg::DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   start,
    input  logic [DATA_WIDTH-1:0]  data,
    input  uet_pkg::cfg_t          cfg,
    output uet_pkg::tx_status_t    status
);

    localparam int IDX_W = $clog2(DATA_WIDTH);
    localparam logic [3:0] LAST_COUNT = 4'(DATA_WIDTH);

    uet_pkg::tx_phase_t    phase_reg, phase_next;
    logic [DATA_WIDTH-1:0] shift_reg, shift_next;
    logic [3:0]            count_reg, count_next;
    logic [7:0]            timer_reg, timer_next;
    logic                  parity_reg, parity_next;
    logic [7:0]            timer_dec;
    logic                  line;

    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        timer_next  = timer_reg;
        parity_next = parity_reg;
        timer_dec   = timer_reg - 8'd1;

        if (phase_reg != uet_pkg::TX_IDLE)
        begin
            timer_next = timer_dec;
            if (timer_dec == 8'd0)
            begin
                timer_next = uet_pkg::at_least_one(cfg.period);
                unique case (phase_reg)
                    uet_pkg::TX_START:
                    begin
                        phase_next = uet_pkg::TX_DATA;
                        count_next = 4'd0;
                    end
                    uet_pkg::TX_DATA:
                    begin
                        count_next = count_reg + 4'd1;
                        if (count_next >= LAST_COUNT)
                        begin
                            phase_next = cfg.parity_en ? uet_pkg::TX_PARITY
                                                       : uet_pkg::TX_STOP;
                        end
                    end
                    uet_pkg::TX_PARITY: phase_next = uet_pkg::TX_STOP;
                    default:            phase_next = uet_pkg::TX_IDLE;
                endcase
            end
        end

        if (start)
        begin
            phase_next  = uet_pkg::TX_START;
            timer_next  = uet_pkg::at_least_one(cfg.period);
            shift_next  = data;
            count_next  = 4'd0;
            parity_next = ^data;
        end
    end

    // Line level follows the state after this tick's update.
    always_comb
    begin
        unique case (phase_next)
            uet_pkg::TX_START:  line = 1'b0;
            uet_pkg::TX_DATA:   line = shift_next[count_next[IDX_W-1:0]];
            uet_pkg::TX_PARITY: line = parity_next;
            default:            line = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= uet_pkg::TX_IDLE;
            shift_reg  <= '0;
            count_reg  <= 4'd0;
            timer_reg  <= 8'd0;
            parity_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            count_reg  <= count_next;
            timer_reg  <= timer_next;
            parity_reg <= parity_next;
        end
    end

    assign status.idle      = (phase_reg == uet_pkg::TX_IDLE);
    assign status.busy_next = (phase_next != uet_pkg::TX_IDLE);
    assign status.line_next = line;

endmodule

@@ hdl/uet_rx.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receiver
// Samples data bits LSB first, skips the parity and stop bits.
// ----------------------------------------------------------------------------
module uet_rx #(
    parameter int DATA_WIDTH = uet_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                start,
    input  logic                rx_in,
    input  uet_pkg::cfg_t       cfg,
    output uet_pkg::rx_status_t status
);

    localparam int IDX_W = $clog2(DATA_WIDTH);
    localparam logic [3:0] LAST_COUNT = 4'(DATA_WIDTH);

    uet_pkg::rx_phase_t    phase_reg, phase_next;
    logic [DATA_WIDTH-1:0] shift_reg, shift_next;
    logic [3:0]            count_reg, count_next;
    logic [7:0]            timer_reg, timer_next;
    logic [7:0]            timer_dec;
    logic                  valid;

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        timer_next = timer_reg;
        timer_dec  = timer_reg - 8'd1;
        valid      = 1'b0;

        if (phase_reg != uet_pkg::RX_IDLE)
        begin
            timer_next = timer_dec;
            if (timer_dec == 8'd0)
            begin
                timer_next = uet_pkg::at_least_one(cfg.period);
                unique case (phase_reg)
                    uet_pkg::RX_DATA:
                    begin
                        shift_next = shift_reg
                                   | (DATA_WIDTH'(rx_in) << count_reg[IDX_W-1:0]);
                        count_next = count_reg + 4'd1;
                        if (count_next >= LAST_COUNT)
                        begin
                            valid      = 1'b1;
                            phase_next = cfg.parity_en ? uet_pkg::RX_PARITY
                                                       : uet_pkg::RX_STOP;
                        end
                    end
                    uet_pkg::RX_PARITY: phase_next = uet_pkg::RX_STOP;
                    default:            phase_next = uet_pkg::RX_IDLE;
                endcase
            end
        end

        if (start)
        begin
            phase_next = uet_pkg::RX_DATA;
            timer_next = uet_pkg::at_least_one(cfg.first_delay);
            shift_next = '0;
            count_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= uet_pkg::RX_IDLE;
            shift_reg <= '0;
            count_reg <= 4'd0;
            timer_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
        end
    end

    assign status.idle      = (phase_reg == uet_pkg::RX_IDLE);
    assign status.busy_next = (phase_next != uet_pkg::RX_IDLE);
    assign status.valid     = valid;
    assign status.rx_data   = valid ? 8'(shift_next) : 8'd0;

endmodule

@@ tb/uart_tick_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transceiver tick checker
// Follows the input, result and register ports of the transceiver, runs its
// own copy of both bit sequencers on every accepted input beat, and compares
// each result beat field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
module uart_tick_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // [0] rx_line, [1] tx_request, [9:2] tx_data, [15:10] zero
    input  logic [15:0]                    s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] tx_line, [1] tx_accepted, [2] link_busy, [3] rx_valid,
    // [11:4] rx_byte, [15:12] zero
    input  logic [15:0]                    m_tdata,
    input  logic                           cfg_we,
    input  logic [uet_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uet_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             mismatches,
    output int                             pending
);

    localparam int DW = uet_pkg::DATA_WIDTH_DEF;

    typedef struct packed {
        logic       tx_line;
        logic       tx_accepted;
        logic       link_busy;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } line_status_t;

    // Register copies.
    logic [7:0] period_reg;
    logic [7:0] delay_reg;
    logic       par_en;

    // Sequencer copies.
    uet_pkg::tx_phase_t tx_st;
    logic [7:0]         tx_shift;
    logic [3:0]         tx_cnt;
    logic [7:0]         tx_tmr;
    logic               tx_par;
    uet_pkg::rx_phase_t rx_st;
    logic [7:0]         rx_tmr;
    logic [7:0]         rx_shift;
    logic [3:0]         rx_cnt;

    line_status_t line_status_q[$];
    line_status_t got_st;
    line_status_t want_st;
    bit           fields_ok;
    int           err_total;

    function automatic logic [7:0] nonzero(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // Advances both sequencers by one tick and returns the line status after it.
    function automatic line_status_t next_line_state(input logic rx_in, input logic req,
                                                     input logic [7:0] data);
        logic [7:0]   per;
        logic         both_idle;
        line_status_t r;
        per       = nonzero(period_reg);
        both_idle = (tx_st == uet_pkg::TX_IDLE) && (rx_st == uet_pkg::RX_IDLE);
        r         = '0;

        if (tx_st != uet_pkg::TX_IDLE)
        begin
            tx_tmr = tx_tmr - 8'd1;
            if (tx_tmr == 8'd0)
            begin
                tx_tmr = per;
                case (tx_st)
                    uet_pkg::TX_START:
                    begin
                        tx_st  = uet_pkg::TX_DATA;
                        tx_cnt = '0;
                    end
                    uet_pkg::TX_DATA:
                    begin
                        tx_cnt = tx_cnt + 4'd1;
                        if (tx_cnt >= DW)
                        begin
                            if (par_en)
                                tx_st = uet_pkg::TX_PARITY;
                            else
                                tx_st = uet_pkg::TX_STOP;
                        end
                    end
                    uet_pkg::TX_PARITY: tx_st = uet_pkg::TX_STOP;
                    default:            tx_st = uet_pkg::TX_IDLE;
                endcase
            end
        end

        if (rx_st != uet_pkg::RX_IDLE)
        begin
            rx_tmr = rx_tmr - 8'd1;
            if (rx_tmr == 8'd0)
            begin
                rx_tmr = per;
                case (rx_st)
                    uet_pkg::RX_DATA:
                    begin
                        if (rx_cnt < DW)
                            rx_shift = rx_shift | (8'(rx_in) << rx_cnt);
                        rx_cnt = rx_cnt + 4'd1;
                        // The byte goes out on the tick of its last data sample.
                        if (rx_cnt >= DW)
                        begin
                            r.rx_valid = 1'b1;
                            r.rx_byte  = rx_shift;
                            if (par_en)
                                rx_st = uet_pkg::RX_PARITY;
                            else
                                rx_st = uet_pkg::RX_STOP;
                        end
                    end
                    uet_pkg::RX_PARITY: rx_st = uet_pkg::RX_STOP;
                    default:            rx_st = uet_pkg::RX_IDLE;
                endcase
            end
        end

        // A start bit wins over a transmit request on the same tick.
        if (both_idle)
        begin
            if (!rx_in)
            begin
                rx_st    = uet_pkg::RX_DATA;
                rx_tmr   = nonzero(delay_reg);
                rx_shift = '0;
                rx_cnt   = '0;
            end
            else if (req)
            begin
                r.tx_accepted = 1'b1;
                tx_st         = uet_pkg::TX_START;
                tx_tmr        = per;
                tx_shift      = data;
                tx_cnt        = '0;
                tx_par        = ^data;
            end
        end

        case (tx_st)
            uet_pkg::TX_START:  r.tx_line = 1'b0;
            uet_pkg::TX_DATA:   r.tx_line = (tx_cnt < DW) ? tx_shift[tx_cnt[2:0]] : 1'b1;
            uet_pkg::TX_PARITY: r.tx_line = tx_par;
            default:            r.tx_line = 1'b1;
        endcase
        r.link_busy = (tx_st != uet_pkg::TX_IDLE) || (rx_st != uet_pkg::RX_IDLE);
        return r;
    endfunction

    function automatic bit field_matches(input string label, input logic [7:0] want_v,
                                         input logic [7:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want_v, got_v);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg = uet_pkg::BIT_PERIOD_RST;
            delay_reg  = uet_pkg::FIRST_SAMPLE_DELAY_RST;
            par_en     = 1'b0;
            tx_st      = uet_pkg::TX_IDLE;
            tx_shift   = '0;
            tx_cnt     = '0;
            tx_tmr     = '0;
            tx_par     = 1'b0;
            rx_st      = uet_pkg::RX_IDLE;
            rx_tmr     = '0;
            rx_shift   = '0;
            rx_cnt     = '0;
            err_total  = 0;
            line_status_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    uet_pkg::CFG_BIT_PERIOD:         period_reg = cfg_wdata;
                    uet_pkg::CFG_FIRST_SAMPLE_DELAY: delay_reg  = cfg_wdata;
                    uet_pkg::CFG_PARITY_ENABLE:      par_en     = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                line_status_q.push_back(next_line_state(s_tdata[0], s_tdata[1], s_tdata[9:2]));

            if (m_tvalid && m_tready)
            begin
                got_st = '{tx_line: m_tdata[0], tx_accepted: m_tdata[1], link_busy: m_tdata[2],
                           rx_valid: m_tdata[3], rx_byte: m_tdata[11:4]};
                if (line_status_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual %0h",
                             $time, m_tdata);
                    err_total++;
                end
                else
                begin
                    want_st   = line_status_q.pop_front();
                    fields_ok = field_matches("tx_line", 8'(want_st.tx_line), 8'(got_st.tx_line))
                        & field_matches("tx_accepted", 8'(want_st.tx_accepted),
                                        8'(got_st.tx_accepted))
                        & field_matches("link_busy", 8'(want_st.link_busy), 8'(got_st.link_busy))
                        & field_matches("rx_valid", 8'(want_st.rx_valid), 8'(got_st.rx_valid))
                        & field_matches("rx_byte", want_st.rx_byte, got_st.rx_byte);
                    if (!fields_ok)
                        err_total++;
                end
            end

            mismatches <= err_total;
            pending    <= line_status_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transceiver testbench
// Feeds the transceiver one bit-timer tick per input beat: serial frames on
// the receive line, transmit requests and line noise, under several bit
// rates and parity settings, with random gaps and stalls on both streams.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CYCLE_LIMIT   = 100_000;
    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [uet_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [15:0]                    s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;
    logic                           cfg_we;
    logic [uet_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [uet_pkg::CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int beats_sent  = 0;
    int idle_pct    = 20;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;

    // Register values as last written, used only to shape the frames.
    logic [7:0] cur_period = uet_pkg::BIT_PERIOD_RST;
    logic [7:0] cur_delay  = uet_pkg::FIRST_SAMPLE_DELAY_RST;
    bit         cur_par    = 1'b0;

    uart_transceiver_even_parity_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    uart_tick_checker line_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin : sink
        int stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic int ticks_of(input logic [7:0] v);
        return (v == 8'd0) ? 1 : int'(v);
    endfunction

    // One input beat is one tick of the bit timers.
    task automatic send_tick(input logic rx, input logic req, input logic [7:0] data);
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tdata  <= {6'd0, data, req, rx};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic drain_link();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] period, input logic [7:0] delay,
                              input bit par, input bit spare);
        drain_link();
        cfg_we    <= 1'b1;
        cfg_index <= uet_pkg::CFG_BIT_PERIOD;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_index <= uet_pkg::CFG_FIRST_SAMPLE_DELAY;
        cfg_wdata <= delay;
        @(posedge clk);
        cfg_index <= uet_pkg::CFG_PARITY_ENABLE;
        cfg_wdata <= {7'd0, par};
        @(posedge clk);
        if (spare)
        begin
            // No register sits at this index, so the write must change nothing.
            cfg_index <= CFG_SPARE;
            cfg_wdata <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_period = period;
        cur_delay  = delay;
        cur_par    = par;
    endtask

    // Serial frame on the receive line; requests are only mixed into the
    // early bits, where the receiver is certain to be busy.
    task automatic drive_rx_frame(input logic [7:0] b, input bit bad_par, input int req_pct);
        logic [10:0] frame_bits;
        int          nbits;
        int          per;
        int          pad;
        int          i;
        per        = ticks_of(cur_period);
        nbits      = cur_par ? 11 : 10;
        frame_bits = cur_par ? {1'b1, (^b) ^ bad_par, b, 1'b0} : {2'b11, b, 1'b0};
        for (i = 0; i < nbits; i++)
            repeat (per)
                send_tick(frame_bits[i], (i < nbits - 2) && ($urandom_range(0, 99) < req_pct),
                          8'($urandom_range(0, 255)));
        // A late first sample keeps the receiver busy past the end of the frame.
        pad = ticks_of(cur_delay) + 1 - 2 * per;
        if (pad < 0)
            pad = 0;
        repeat (pad + $urandom_range(0, 2))
            send_tick(1'b1, 1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic drive_tx_frame(input logic [7:0] data);
        int fill;
        fill = (cur_par ? 11 : 10) * ticks_of(cur_period);
        send_tick(1'b1, 1'b1, data);
        // The link stays busy for the whole frame, so anything offered here is ignored.
        repeat (fill)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2))
            send_tick(1'b1, 1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic run_mixed(input int until_beats);
        int kind;
        while (beats_sent < until_beats)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 6)
            begin
                drive_rx_frame(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                               ($urandom_range(0, 1) == 1) ? 30 : 0);
            end
            else if (kind < 9)
            begin
                drive_tx_frame(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)));
                // Let whatever the noise started run out before the next frame.
                repeat (ticks_of(cur_delay) + 11 * ticks_of(cur_period))
                    send_tick(1'b1, 1'b0, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin : stimulus
        int p;
        int d;
        int ph;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= uet_pkg::CFG_BIT_PERIOD;
        cfg_wdata <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register values after reset: one receive frame at that rate.
        drive_rx_frame(8'h33, 1'b0, 0);

        // Shortest bit time with parity. Every tick of the receive frame but its last
        // two bits carries a request, so the start and a request meet on its first tick.
        set_config(8'd1, 8'd1, 1'b1, 1'b0);
        drive_tx_frame(8'h00);
        drive_rx_frame(8'hFF, 1'b0, 100);

        // Zero period and delay behave as one tick.
        set_config(8'd0, 8'd0, 1'b0, 1'b1);
        run_mixed(beats_sent + 80);

        for (ph = 0; ph < 8; ph++)
        begin
            p = $urandom_range(1, 5);
            if ($urandom_range(0, 3) == 0)
                d = $urandom_range(1, 12);
            else
                d = p + p / 2 + $urandom_range(0, 1);
            idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 40);
            set_config(p[7:0], d[7:0], 1'($urandom_range(0, 1)), 1'b0);
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == 4)
            begin
                run_mixed(beats_sent + 30);
                drain_link();
            end
            run_mixed(beats_sent + 30);
        end

        // Longest first-sample delay at the shortest bit time.
        idle_pct = 10;
        set_config(8'd1, 8'd255, 1'b0, 1'b0);
        drive_rx_frame(8'($urandom_range(0, 255)), 1'b0, 0);

        calm = 1'b1;
        set_config(8'd3, 8'd4, 1'b1, 1'b0);
        run_mixed(beats_sent + 70);

        drain_link();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
